>>> rtl/gzip_member_deframer_unit_assert.svh
// Assertion macros used by the checker file gmd_checker.sv.
`ifndef GZIP_MEMBER_DEFRAMER_UNIT_ASSERT_SVH
`define GZIP_MEMBER_DEFRAMER_UNIT_ASSERT_SVH

// Checked only while reset is low.
`define GMD_ASSERT_CHK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("gzip deframer check failed");

// Checked at every clock edge, reset included.
`define GMD_ASSERT_ALL(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("gzip deframer check failed");

`endif

>>> rtl/gmd_pkg.sv
package gmd_pkg;

   localparam int TRAILER_BYTES = 8;
   localparam int FILL_W = $clog2(TRAILER_BYTES + 1);
   localparam int HB_IDX_W = $clog2(TRAILER_BYTES);

   localparam int RSP_QUEUE_DEPTH = 3;
   localparam int QCNT_W = $clog2(RSP_QUEUE_DEPTH + 1);

   localparam logic [7:0] ID1_BYTE = 8'h1f;
   localparam logic [7:0] ID2_BYTE = 8'h8b;
   localparam logic [7:0] CM_DEFLATE = 8'h08;

   localparam int FB_HCRC = 0;
   localparam int FB_EXTRA = 1;
   localparam int FB_NAME = 2;
   localparam int FB_COMMENT = 3;

   localparam logic [15:0] FIXED_SKIP = 16'd6;
   localparam logic [15:0] HCRC_SKIP = 16'd2;

   typedef enum logic [1:0] {
      KIND_DATA = 2'd0,
      KIND_DONE = 2'd1,
      KIND_BAD_HEADER = 2'd2,
      KIND_TRUNCATED = 2'd3
   } gmd_kind_type;

   typedef enum logic [3:0] {
      PH_ID1 = 4'd0,
      PH_ID2 = 4'd1,
      PH_CM = 4'd2,
      PH_FLG = 4'd3,
      PH_FIXED = 4'd4,
      PH_XLO = 4'd5,
      PH_XHI = 4'd6,
      PH_EXTRA = 4'd7,
      PH_NAME = 4'd8,
      PH_COMMENT = 4'd9,
      PH_HCRC = 4'd10,
      PH_PAYLOAD = 4'd11,
      PH_FAULT = 4'd12
   } gmd_phase_type;

   typedef struct packed {
      gmd_kind_type kind;
      logic [7:0] data_byte;
      logic [31:0] crc_value;
      logic [31:0] original_size;
      logic [31:0] payload_length;
      logic last_result;
   } gmd_result_type;

   typedef struct packed {
      logic [1:0] count;
      gmd_result_type first;
      gmd_result_type second;
   } gmd_step_type;

endpackage

>>> rtl/gmd_if.sv
interface gmd_req_if;
   logic valid;
   logic ready;
   logic [7:0] in_byte;
   logic end_of_stream;

   modport source (output valid, in_byte, end_of_stream, input ready);
   modport sink (input valid, in_byte, end_of_stream, output ready);
endinterface

interface gmd_rsp_if import gmd_pkg::*; ();
   logic valid;
   logic ready;
   gmd_kind_type kind;
   logic [7:0] data_byte;
   logic [31:0] crc_value;
   logic [31:0] original_size;
   logic [31:0] payload_length;
   logic last_result;

   modport source (output valid, kind, data_byte, crc_value, original_size,
                   payload_length, last_result, input ready);
   modport sink (input valid, kind, data_byte, crc_value, original_size,
                 payload_length, last_result, output ready);
endinterface

interface gmd_csr_if;
   logic valid;
   logic ready;
   logic passthrough_mode;

   modport source (output valid, passthrough_mode, input ready);
   modport sink (input valid, passthrough_mode, output ready);
endinterface

>>> rtl/gmd_parser.sv
module gmd_parser import gmd_pkg::*; (
   input logic clock,
   input logic reset,
   input logic step,
   input logic [7:0] in_byte,
   input logic end_of_stream,
   input logic passthrough_mode,
   output gmd_step_type step_out
);

   gmd_phase_type phase_ff, phase_in, phase_mid;
   logic [3:0] flags_ff, flags_in;
   logic [15:0] skip_ff, skip_in;
   logic [7:0] xlo_ff, xlo_in;
   logic [7:0] hb_ff [TRAILER_BYTES];
   logic [7:0] hb_in [TRAILER_BYTES];
   logic [FILL_W-1:0] fill_ff, fill_in, fill_mid;
   logic [31:0] count_ff, count_in, count_mid;
   logic bad_hdr;
   logic push_out;

   function automatic gmd_phase_type next_opt(input logic [3:0] flags,
                                              input logic [1:0] done_upto);
      gmd_phase_type ph;
      priority if (done_upto < 2'd1 && flags[FB_EXTRA]) begin
         ph = PH_XLO;
      end else if (done_upto < 2'd2 && flags[FB_NAME]) begin
         ph = PH_NAME;
      end else if (done_upto < 2'd3 && flags[FB_COMMENT]) begin
         ph = PH_COMMENT;
      end else if (flags[FB_HCRC]) begin
         ph = PH_HCRC;
      end else begin
         ph = PH_PAYLOAD;
      end
      return ph;
   endfunction

   always_comb begin
      phase_mid = phase_ff;
      flags_in = flags_ff;
      skip_in = skip_ff;
      xlo_in = xlo_ff;
      hb_in = hb_ff;
      fill_mid = fill_ff;
      count_mid = count_ff;
      bad_hdr = 1'b0;
      push_out = 1'b0;
      if (step && !passthrough_mode) begin
         unique case (phase_ff)
            PH_ID1: begin
               if (in_byte != ID1_BYTE) bad_hdr = 1'b1;
               else phase_mid = PH_ID2;
            end
            PH_ID2: begin
               if (in_byte != ID2_BYTE) bad_hdr = 1'b1;
               else phase_mid = PH_CM;
            end
            PH_CM: begin
               if (in_byte != CM_DEFLATE) bad_hdr = 1'b1;
               else phase_mid = PH_FLG;
            end
            PH_FLG: begin
               flags_in = in_byte[4:1];
               skip_in = FIXED_SKIP;
               phase_mid = PH_FIXED;
            end
            PH_FIXED: begin
               skip_in = skip_ff - 16'd1;
               if (skip_ff == 16'd1) phase_mid = next_opt(flags_ff, 2'd0);
            end
            PH_XLO: begin
               xlo_in = in_byte;
               phase_mid = PH_XHI;
            end
            PH_XHI: begin
               skip_in = {in_byte, xlo_ff};
               if ({in_byte, xlo_ff} == 16'd0) phase_mid = next_opt(flags_ff, 2'd1);
               else phase_mid = PH_EXTRA;
            end
            PH_EXTRA: begin
               skip_in = skip_ff - 16'd1;
               if (skip_ff == 16'd1) phase_mid = next_opt(flags_ff, 2'd1);
            end
            PH_NAME: begin
               if (in_byte == 8'd0) phase_mid = next_opt(flags_ff, 2'd2);
            end
            PH_COMMENT: begin
               if (in_byte == 8'd0) phase_mid = next_opt(flags_ff, 2'd3);
            end
            PH_HCRC: begin
               skip_in = skip_ff - 16'd1;
               if (skip_ff == 16'd1) phase_mid = PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
               if (fill_ff < FILL_W'(TRAILER_BYTES)) begin
                  hb_in[fill_ff[HB_IDX_W-1:0]] = in_byte;
                  fill_mid = fill_ff + FILL_W'(1);
               end else begin
                  push_out = 1'b1;
                  for (int i = 0; i < TRAILER_BYTES - 1; i++) begin
                     hb_in[i] = hb_ff[i+1];
                  end
                  hb_in[TRAILER_BYTES-1] = in_byte;
                  if (count_ff != 32'hffff_ffff) count_mid = count_ff + 32'd1;
               end
            end
            default: begin
            end
         endcase
         if (bad_hdr) phase_mid = PH_FAULT;
         if (phase_mid == PH_HCRC && phase_ff != PH_HCRC) skip_in = HCRC_SKIP;
      end
      phase_in = phase_mid;
      fill_in = fill_mid;
      count_in = count_mid;
      if (step && !passthrough_mode && end_of_stream) begin
         phase_in = PH_ID1;
         flags_in = 4'd0;
         skip_in = 16'd0;
         xlo_in = 8'd0;
         fill_in = '0;
         count_in = 32'd0;
      end
   end

   always_comb begin
      gmd_result_type r_pay;
      gmd_result_type r_bad;
      gmd_result_type r_end;
      logic has_end;
      r_pay = '0;
      r_pay.kind = KIND_DATA;
      r_pay.data_byte = hb_ff[0];
      r_bad = '0;
      r_bad.kind = KIND_BAD_HEADER;
      r_bad.last_result = 1'b1;
      r_end = '0;
      r_end.last_result = 1'b1;
      has_end = 1'b0;
      step_out = '0;
      if (end_of_stream) begin
         if (phase_mid == PH_PAYLOAD && fill_mid == FILL_W'(TRAILER_BYTES)) begin
            has_end = 1'b1;
            r_end.kind = KIND_DONE;
            r_end.crc_value = {hb_in[3], hb_in[2], hb_in[1], hb_in[0]};
            r_end.original_size = {hb_in[7], hb_in[6], hb_in[5], hb_in[4]};
            r_end.payload_length = count_mid;
         end else if (phase_mid != PH_FAULT) begin
            has_end = 1'b1;
            r_end.kind = KIND_TRUNCATED;
         end
      end
      if (step) begin
         priority if (passthrough_mode) begin
            step_out.count = 2'd1;
            step_out.first = '0;
            step_out.first.kind = KIND_DATA;
            step_out.first.data_byte = in_byte;
            step_out.first.last_result = 1'b1;
         end else if (push_out) begin
            step_out.first = r_pay;
            if (has_end) begin
               step_out.count = 2'd2;
               step_out.second = r_end;
            end else begin
               step_out.count = 2'd1;
               step_out.first.last_result = 1'b1;
            end
         end else if (bad_hdr) begin
            step_out.count = 2'd1;
            step_out.first = r_bad;
         end else if (has_end) begin
            step_out.count = 2'd1;
            step_out.first = r_end;
         end else begin
            step_out.count = 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_ID1;
         flags_ff <= 4'd0;
         skip_ff <= 16'd0;
         xlo_ff <= 8'd0;
         fill_ff <= '0;
         count_ff <= 32'd0;
      end else begin
         phase_ff <= phase_in;
         flags_ff <= flags_in;
         skip_ff <= skip_in;
         xlo_ff <= xlo_in;
         fill_ff <= fill_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      hb_ff <= hb_in;
   end

endmodule

>>> rtl/gzip_member_deframer_unit.sv
// Channel   Port      Direction  Carries
// req       req_bus   in         in_byte, end_of_stream
// rsp       rsp_bus   out        kind, data_byte, crc_value, original_size,
//                                payload_length, last_result
// csr       csr_bus   in         passthrough_mode, always ready
//
// One item is parsed in the cycle it is accepted and its results land in a
// three-entry result queue, so a byte can be taken every cycle.
// The input is ready while the queue holds at most one result; an item that
// yields two results therefore drops ready until the queue drains to one.
// A stalled result side fills the queue and holds ready low until it drains.
// Synchronous reset clears the parser state, the queue and the mode bit.
module gzip_member_deframer_unit import gmd_pkg::*; (
   input logic clock,
   input logic reset,
   gmd_req_if.sink req_bus,
   gmd_rsp_if.source rsp_bus,
   gmd_csr_if.sink csr_bus
);

   logic mode_ff, mode_in;
   gmd_result_type q_ff [RSP_QUEUE_DEPTH];
   gmd_result_type q_in [RSP_QUEUE_DEPTH];
   logic [QCNT_W-1:0] cnt_ff, cnt_in, cnt_p;
   logic accept;
   logic pop;
   gmd_step_type step_out;

   assign req_bus.ready = (cnt_ff <= QCNT_W'(1));
   assign accept = req_bus.valid && req_bus.ready;
   assign pop = rsp_bus.valid && rsp_bus.ready;
   assign csr_bus.ready = 1'b1;

   gmd_parser u_parser (
      .clock(clock),
      .reset(reset),
      .step(accept),
      .in_byte(req_bus.in_byte),
      .end_of_stream(req_bus.end_of_stream),
      .passthrough_mode(mode_ff),
      .step_out(step_out)
   );

   always_comb begin
      mode_in = mode_ff;
      if (csr_bus.valid) mode_in = csr_bus.passthrough_mode;
   end

   always_comb begin
      cnt_p = cnt_ff - QCNT_W'(pop);
      for (int i = 0; i < RSP_QUEUE_DEPTH; i++) begin
         if (pop && i < RSP_QUEUE_DEPTH - 1) q_in[i] = q_ff[i+1];
         else q_in[i] = q_ff[i];
         if (accept && step_out.count != 2'd0 && QCNT_W'(i) == cnt_p) begin
            q_in[i] = step_out.first;
         end
         if (accept && step_out.count == 2'd2 && QCNT_W'(i) == QCNT_W'(cnt_p + 1'b1)) begin
            q_in[i] = step_out.second;
         end
      end
      cnt_in = cnt_p + (accept ? QCNT_W'(step_out.count) : QCNT_W'(0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         mode_ff <= mode_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

   assign rsp_bus.valid = (cnt_ff != '0);
   assign rsp_bus.kind = q_ff[0].kind;
   assign rsp_bus.data_byte = q_ff[0].data_byte;
   assign rsp_bus.crc_value = q_ff[0].crc_value;
   assign rsp_bus.original_size = q_ff[0].original_size;
   assign rsp_bus.payload_length = q_ff[0].payload_length;
   assign rsp_bus.last_result = q_ff[0].last_result;

endmodule

>>> rtl/gmd_checker.sv
`include "gzip_member_deframer_unit_assert.svh"

module gmd_checker import gmd_pkg::*; (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input gmd_kind_type rsp_kind,
   input logic [7:0] rsp_data_byte,
   input logic [31:0] rsp_crc_value,
   input logic [31:0] rsp_original_size,
   input logic [31:0] rsp_payload_length,
   input logic rsp_last_result
);

   logic status_item;
   logic non_done_item;
   logic trailer_clear;
   logic stalled;
   logic [9:0] rsp_head;

   assign status_item = rsp_valid && rsp_kind != KIND_DATA;
   assign non_done_item = rsp_valid && rsp_kind != KIND_DONE;
   assign trailer_clear = rsp_crc_value == 32'd0 && rsp_original_size == 32'd0
      && rsp_payload_length == 32'd0;
   assign stalled = rsp_valid && !rsp_ready;
   assign rsp_head = {rsp_kind, rsp_data_byte};

   // The result queue is empty right after reset.
   `GMD_ASSERT_ALL(a_empty_after_reset, clock, reset |=> !rsp_valid)

   // Status items always close the results of their input item.
   `GMD_ASSERT_CHK(a_status_is_last, clock, reset, status_item |-> rsp_last_result)

   // Trailer fields are zero except on a completed member.
   `GMD_ASSERT_CHK(a_trailer_zero, clock, reset, non_done_item |-> trailer_clear)

   // A stalled item keeps its kind and data byte.
   `GMD_ASSERT_CHK(a_stall_holds, clock, reset, stalled |=> rsp_valid && $stable(rsp_head))

endmodule

bind gzip_member_deframer_unit gmd_checker u_gmd_checker (
   .clock(clock),
   .reset(reset),
   .rsp_valid(rsp_bus.valid),
   .rsp_ready(rsp_bus.ready),
   .rsp_kind(rsp_bus.kind),
   .rsp_data_byte(rsp_bus.data_byte),
   .rsp_crc_value(rsp_bus.crc_value),
   .rsp_original_size(rsp_bus.original_size),
   .rsp_payload_length(rsp_bus.payload_length),
   .rsp_last_result(rsp_bus.last_result)
);

>>> test/tb_top.sv
module tb_top;
   import gmd_pkg::*;

   typedef struct {
      logic [7:0] in_byte;
      logic end_of_stream;
   } stream_byte_type;

   logic clock = 1'b0;
   logic reset;

   gmd_req_if req_bus ();
   gmd_rsp_if rsp_bus ();
   gmd_csr_if csr_bus ();

   gzip_member_deframer_unit dut (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_bus(csr_bus)
   );

   always #4 clock = ~clock;

   stream_byte_type byte_stream_q[$];
   gmd_result_type expected_results_q[$];

   logic req_fire = 1'b0;
   logic rsp_fire = 1'b0;
   logic csr_fire = 1'b0;

   int bytes_queued = 0;
   int bytes_accepted = 0;
   int results_checked = 0;
   int failures = 0;
   int kind_seen[4] = '{0, 0, 0, 0};

   int send_gap = 0;
   logic send_burst = 1'b0;
   int recv_stall = 0;
   logic recv_burst = 1'b0;
   int hold_left = 0;
   logic hold_armed = 1'b0;
   logic hold_done = 1'b0;

   // Shadow copy of the deframer state.
   logic pass_mode = 1'b0;
   gmd_phase_type phase = PH_ID1;
   logic [3:0] hdr_flags = '0;
   logic [15:0] skip_left = '0;
   logic [7:0] xlen_low = '0;
   logic [7:0] held_bytes[TRAILER_BYTES];
   logic [FILL_W-1:0] held_count = '0;
   logic [31:0] payload_total = '0;

   function automatic gmd_result_type pack_result(input gmd_kind_type kind,
                                                  input logic [7:0] data,
                                                  input logic [31:0] crc,
                                                  input logic [31:0] isize,
                                                  input logic [31:0] plen);
      gmd_result_type r;
      r.kind = kind;
      r.data_byte = data;
      r.crc_value = crc;
      r.original_size = isize;
      r.payload_length = plen;
      r.last_result = 1'b0;
      return r;
   endfunction

   function automatic void clear_parser();
      phase = PH_ID1;
      hdr_flags = '0;
      skip_left = '0;
      xlen_low = '0;
      held_count = '0;
      payload_total = '0;
   endfunction

   function automatic void next_header_part(input int done_upto);
      if (done_upto < 1 && hdr_flags[FB_EXTRA]) begin
         phase = PH_XLO;
      end else if (done_upto < 2 && hdr_flags[FB_NAME]) begin
         phase = PH_NAME;
      end else if (done_upto < 3 && hdr_flags[FB_COMMENT]) begin
         phase = PH_COMMENT;
      end else if (hdr_flags[FB_HCRC]) begin
         skip_left = HCRC_SKIP;
         phase = PH_HCRC;
      end else begin
         phase = PH_PAYLOAD;
      end
   endfunction

   task automatic deframe_byte(input logic [7:0] b, input logic eos);
      gmd_result_type res[2];
      int n;
      int i;
      logic bad;
      n = 0;
      bad = 1'b0;
      if (pass_mode) begin
         res[0] = pack_result(KIND_DATA, b, '0, '0, '0);
         n = 1;
      end else begin
         case (phase)
            PH_ID1: if (b != ID1_BYTE) bad = 1'b1; else phase = PH_ID2;
            PH_ID2: if (b != ID2_BYTE) bad = 1'b1; else phase = PH_CM;
            PH_CM: if (b != CM_DEFLATE) bad = 1'b1; else phase = PH_FLG;
            PH_FLG: begin
               hdr_flags = b[4:1];
               skip_left = FIXED_SKIP;
               phase = PH_FIXED;
            end
            PH_FIXED: begin
               skip_left = skip_left - 16'd1;
               if (skip_left == 0) next_header_part(0);
            end
            PH_XLO: begin
               xlen_low = b;
               phase = PH_XHI;
            end
            PH_XHI: begin
               skip_left = {b, xlen_low};
               if (skip_left == 0) next_header_part(1);
               else phase = PH_EXTRA;
            end
            PH_EXTRA: begin
               skip_left = skip_left - 16'd1;
               if (skip_left == 0) next_header_part(1);
            end
            PH_NAME: if (b == 8'd0) next_header_part(2);
            PH_COMMENT: if (b == 8'd0) next_header_part(3);
            PH_HCRC: begin
               skip_left = skip_left - 16'd1;
               if (skip_left == 0) phase = PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
               if (held_count < TRAILER_BYTES) begin
                  held_bytes[held_count] = b;
                  held_count = held_count + 1'b1;
               end else begin
                  res[n] = pack_result(KIND_DATA, held_bytes[0], '0, '0, '0);
                  n++;
                  for (i = 0; i < TRAILER_BYTES - 1; i++) held_bytes[i] = held_bytes[i + 1];
                  held_bytes[TRAILER_BYTES - 1] = b;
                  if (payload_total != '1) payload_total = payload_total + 1;
               end
            end
            default: ;
         endcase
         if (bad) begin
            res[n] = pack_result(KIND_BAD_HEADER, '0, '0, '0, '0);
            n++;
            phase = PH_FAULT;
         end
         if (eos) begin
            if (phase == PH_PAYLOAD && held_count == TRAILER_BYTES) begin
               res[n] = pack_result(KIND_DONE, '0,
                  {held_bytes[3], held_bytes[2], held_bytes[1], held_bytes[0]},
                  {held_bytes[7], held_bytes[6], held_bytes[5], held_bytes[4]},
                  payload_total);
               n++;
            end else if (phase < PH_FAULT) begin
               res[n] = pack_result(KIND_TRUNCATED, '0, '0, '0, '0);
               n++;
            end
            clear_parser();
         end
      end
      if (n > 0) res[n - 1].last_result = 1'b1;
      for (i = 0; i < n; i++) expected_results_q.push_back(res[i]);
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         failures++;
      end
   endtask

   task automatic check_result();
      gmd_result_type want;
      results_checked++;
      kind_seen[rsp_bus.kind]++;
      if (expected_results_q.size() == 0) begin
         $error("result of kind %0d arrived with nothing expected", rsp_bus.kind);
         failures++;
      end else begin
         want = expected_results_q.pop_front();
         check_field("kind", want.kind, rsp_bus.kind);
         check_field("data_byte", want.data_byte, rsp_bus.data_byte);
         check_field("crc_value", want.crc_value, rsp_bus.crc_value);
         check_field("original_size", want.original_size, rsp_bus.original_size);
         check_field("payload_length", want.payload_length, rsp_bus.payload_length);
         check_field("last_result", want.last_result, rsp_bus.last_result);
      end
   endtask

   always @(posedge clock) begin
      req_fire = !reset && req_bus.valid && req_bus.ready;
      rsp_fire = !reset && rsp_bus.valid && rsp_bus.ready;
      csr_fire = !reset && csr_bus.valid && csr_bus.ready;
      if (reset) begin
         pass_mode = 1'b0;
         clear_parser();
      end
      if (csr_fire) pass_mode = csr_bus.passthrough_mode;
      if (req_fire) begin
         deframe_byte(req_bus.in_byte, req_bus.end_of_stream);
         bytes_accepted++;
      end
      if (rsp_fire) check_result();
   end

   always @(negedge clock) begin
      stream_byte_type next_item;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (req_fire || !req_bus.valid) begin
         if (send_gap > 0) begin
            send_gap--;
            req_bus.valid <= 1'b0;
         end else if (byte_stream_q.size() > 0) begin
            next_item = byte_stream_q.pop_front();
            req_bus.valid <= 1'b1;
            req_bus.in_byte <= next_item.in_byte;
            req_bus.end_of_stream <= next_item.end_of_stream;
            if ($urandom_range(0, 63) == 0) send_burst = !send_burst;
            send_gap = send_burst ? 0 : $urandom_range(0, 3);
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (hold_armed && !hold_done) begin
            hold_left = 80;
            hold_done = 1'b1;
         end
         if (rsp_fire) begin
            if ($urandom_range(0, 63) == 0) recv_burst = !recv_burst;
            recv_stall = recv_burst ? 0 : $urandom_range(0, 3);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (recv_stall > 0) begin
            recv_stall--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   task automatic add_byte(input logic [7:0] b, input logic eos);
      stream_byte_type item;
      item.in_byte = b;
      item.end_of_stream = eos;
      byte_stream_q.push_back(item);
      bytes_queued++;
   endtask

   task automatic queue_bytes(ref logic [7:0] m[$], input int from, input int upto,
                              input logic end_flag);
      int i;
      for (i = from; i < upto; i++) add_byte(m[i], end_flag && (i == upto - 1));
   endtask

   task automatic build_member(input logic [7:0] flg, input int xlen, input int name_len,
                               input int comment_len, input int pay_len,
                               ref logic [7:0] m[$]);
      int i;
      m = {};
      m.push_back(ID1_BYTE);
      m.push_back(ID2_BYTE);
      m.push_back(CM_DEFLATE);
      m.push_back(flg);
      for (i = 0; i < FIXED_SKIP; i++) m.push_back(8'($urandom_range(0, 255)));
      if (flg[FB_EXTRA + 1]) begin
         m.push_back(xlen[7:0]);
         m.push_back(xlen[15:8]);
         for (i = 0; i < xlen; i++) m.push_back(8'($urandom_range(0, 255)));
      end
      if (flg[FB_NAME + 1]) begin
         for (i = 0; i < name_len; i++) m.push_back(8'($urandom_range(1, 255)));
         m.push_back(8'd0);
      end
      if (flg[FB_COMMENT + 1]) begin
         for (i = 0; i < comment_len; i++) m.push_back(8'($urandom_range(1, 255)));
         m.push_back(8'd0);
      end
      if (flg[FB_HCRC + 1]) begin
         for (i = 0; i < HCRC_SKIP; i++) m.push_back(8'($urandom_range(0, 255)));
      end
      for (i = 0; i < pay_len + TRAILER_BYTES; i++) m.push_back(8'($urandom_range(0, 255)));
   endtask

   task automatic random_member();
      logic [7:0] m[$];
      logic [7:0] flg;
      int pick;
      int xlen;
      int pay_len;
      int pos;
      int count;
      int i;
      pick = $urandom_range(0, 99);
      flg = 8'($urandom_range(0, 255));
      xlen = ($urandom_range(0, 19) == 0) ? $urandom_range(256, 300) : $urandom_range(0, 6);
      pay_len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 20);
      build_member(flg, xlen, $urandom_range(0, 5), $urandom_range(0, 5), pay_len, m);
      if (pick < 70) begin
         queue_bytes(m, 0, m.size(), 1'b1);
      end else if (pick < 85) begin
         queue_bytes(m, 0, $urandom_range(1, m.size() - 1), 1'b1);
      end else if (pick < 93) begin
         pos = $urandom_range(0, 2);
         m[pos] = m[pos] ^ 8'($urandom_range(1, 255));
         queue_bytes(m, 0, m.size(), 1'b1);
      end else begin
         count = $urandom_range(1, 6);
         for (i = 0; i < count; i++) add_byte(8'($urandom_range(0, 255)), i == count - 1);
      end
   endtask

   task automatic random_members(input int count);
      int target;
      target = bytes_queued + count;
      while (bytes_queued < target) random_member();
   endtask

   task automatic random_raw_bytes(input int count);
      int i;
      for (i = 0; i < count; i++)
         add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
   endtask

   task automatic wait_idle();
      do @(negedge clock); while (bytes_accepted != bytes_queued || expected_results_q.size() != 0);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_mode(input logic mode);
      wait_idle();
      csr_bus.valid <= 1'b1;
      csr_bus.passthrough_mode <= mode;
      do @(negedge clock); while (!csr_fire);
      csr_bus.valid <= 1'b0;
   endtask

   initial begin
      logic [7:0] m[$];
      int guard;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.in_byte = '0;
      req_bus.end_of_stream = 1'b0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.passthrough_mode = 1'b0;
      repeat (4) @(negedge clock);
      reset = 1'b0;

      write_mode(1'b0);
      build_member(8'h00, 0, 0, 0, 0, m);
      queue_bytes(m, 0, m.size(), 1'b1);
      build_member(8'hff, 0, 3, 2, 2, m);
      m[m.size() - 10] = 8'h00;
      m[m.size() - 9] = 8'hff;
      queue_bytes(m, 0, m.size(), 1'b1);
      build_member(8'h04, 3, 0, 0, 5, m);
      queue_bytes(m, 0, m.size(), 1'b1);
      build_member(8'h00, 0, 0, 0, 0, m);
      queue_bytes(m, 0, m.size() - 1, 1'b1);
      queue_bytes(m, 0, 5, 1'b1);
      add_byte(8'h00, 1'b0);
      add_byte(8'h8b, 1'b0);
      add_byte(8'h08, 1'b1);
      add_byte(ID1_BYTE, 1'b0);
      add_byte(8'h8c, 1'b1);
      add_byte(ID1_BYTE, 1'b0);
      add_byte(ID2_BYTE, 1'b0);
      add_byte(8'h07, 1'b1);
      add_byte(ID1_BYTE, 1'b1);
      add_byte(8'hff, 1'b1);

      // A member interrupted by passthrough traffic must resume where it stopped.
      build_member(8'h10, 0, 0, 2, 12, m);
      queue_bytes(m, 0, 14, 1'b0);
      write_mode(1'b1);
      add_byte(8'h00, 1'b0);
      add_byte(8'hff, 1'b1);
      add_byte(ID1_BYTE, 1'b0);
      write_mode(1'b0);
      queue_bytes(m, 14, m.size(), 1'b1);

      wait_idle();
      random_members(400);
      hold_armed = 1'b1;
      write_mode(1'b1);
      random_raw_bytes(120);
      write_mode(1'b0);
      random_members(400);
      write_mode(1'b1);
      random_raw_bytes(60);
      write_mode(1'b0);
      random_members(100);

      guard = 0;
      while ((bytes_accepted != bytes_queued || expected_results_q.size() != 0)
             && guard < 50000) begin
         @(negedge clock);
         guard++;
      end
      repeat (10) @(negedge clock);
      if (bytes_accepted != bytes_queued || expected_results_q.size() != 0) begin
         $error("%0d bytes not taken, %0d results never arrived",
                bytes_queued - bytes_accepted, expected_results_q.size());
         failures++;
      end
      $display("Fed %0d bytes and checked %0d results: %0d payload, %0d done, %0d bad header,",
               bytes_accepted, results_checked, kind_seen[KIND_DATA], kind_seen[KIND_DONE],
               kind_seen[KIND_BAD_HEADER]);
      $display("%0d truncated, across parse and passthrough modes with a long output stall.",
               kind_seen[KIND_TRUNCATED]);
      if (failures == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Run timed out.");
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

>>> gzip_member_deframer_unit.f
+incdir+rtl
rtl/gmd_pkg.sv
rtl/gmd_if.sv
rtl/gmd_parser.sv
rtl/gzip_member_deframer_unit.sv
rtl/gmd_checker.sv
test/tb_top.sv
